### design/psc_pkg.sv
// Shared types and constants for the postfix stack calculator.
// Mode, status and ALU operation codes, plus the ALU handshake structs.
// No dependencies.
package psc_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned STACK_DEPTH_DEF = 256;

	typedef enum logic [2:0] {
		MODE_PUSH      = 3'd0,
		MODE_POP       = 3'd1,
		MODE_ADD       = 3'd2,
		MODE_SUB       = 3'd3,
		MODE_MUL       = 3'd4,
		MODE_DIV       = 3'd5,
		MODE_PEEK_TOP  = 3'd6,
		MODE_PEEK_BOT  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_DIVZERO = 3'd2,
		ST_BADIDX  = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

endpackage

### design/psc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module psc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/psc_alu.sv
// Shared arithmetic unit: registered add, subtract and low-word multiply,
// and a 32-step restoring divider with floor correction. Uses psc_pkg.
module psc_alu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  psc_pkg::alu_req_t               req,
	input  logic [psc_pkg::DATA_W-1:0]      a,
	input  logic [psc_pkg::DATA_W-1:0]      b,
	output psc_pkg::alu_rsp_t               rsp,
	output logic [psc_pkg::DATA_W-1:0]      y
);
	import psc_pkg::*;

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_FIX
	} alu_state_t;

	alu_state_t          state_q;
	logic [4:0]          step_q;
	logic                done_q;
	logic                neg_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W-1:0]   dvs_q;
	logic [DATA_W-1:0]   y_q;

	logic [DATA_W-1:0]   a_mag;
	logic [DATA_W-1:0]   b_mag;
	logic [DATA_W:0]     trial;
	logic [DATA_W:0]     diff;
	logic [DATA_W-1:0]   prod;

	assign a_mag = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
	assign b_mag = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
	assign prod  = a * b;
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					done_q <= req.start && (req.op != ALU_DIV);
					if (req.start) begin
						case (req.op)
							ALU_ADD: begin
								y_q <= a + b;
							end
							ALU_SUB: begin
								y_q <= a - b;
							end
							ALU_MUL: begin
								y_q <= prod;
							end
							default: begin
								rem_q   <= '0;
								quo_q   <= a_mag;
								dvs_q   <= b_mag;
								neg_q   <= a[DATA_W-1] ^ b[DATA_W-1];
								step_q  <= '1;
								state_q <= A_DIV;
							end
						endcase
					end
				end
				A_DIV: begin
					// one quotient bit per cycle, MSB first
					done_q <= 1'b0;
					if (!diff[DATA_W]) begin
						rem_q <= diff[DATA_W-1:0];
					end else begin
						rem_q <= trial[DATA_W-1:0];
					end
					quo_q  <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
					step_q <= step_q - 5'd1;
					if (step_q == '0) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					// round toward minus infinity when the signs differ
					if (!neg_q) begin
						y_q <= quo_q;
					end else if (rem_q != '0) begin
						y_q <= ~quo_q;
					end else begin
						y_q <= ~quo_q + DATA_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign y        = y_q;

endmodule

### design/postfix_stack_calculator_unit.sv
// Postfix stack calculator: a bounded stack of signed 32-bit entries.
// Input channel (in_valid / in_stall) carries mode, value and index; one beat
// is one operation. Output channel (out_valid / out_stall) returns one beat
// per operation with result, status and the stack depth afterwards.
// A beat is taken at a rising edge with valid high and stall low.
// Path from accepted input beat to output valid: push and operations
// rejected at decode go from decode to finish, pop and peek add a memory read,
// binary operations read both operands and divide by zero ends there, while
// add, subtract, multiply and divide then wait for the ALU. The 32-step shared
// divider makes divide the slowest; the stack memory's single read port makes a
// binary operation read its two operands in successive cycles. One operation
// is in flight at a time: in_stall stays high from acceptance until the result
// is loaded for output, and the next beat can be taken in the cycle after that.
// The output register holds a finished beat while out_stall is high, and a
// new input beat is taken meanwhile; the next result waits for that slot.
// Reset (arst_n low) empties the stack; memory contents are not cleared and
// an entry is read only after it was pushed.
// Uses psc_pkg, psc_ram and psc_alu.
module postfix_stack_calculator_unit #(
	parameter int unsigned STACK_DEPTH = psc_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  mode,
	input  logic signed [31:0]          value,
	input  logic [7:0]                  index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          result,
	output logic [2:0]                  status,
	output logic [8:0]                  depth
);
	import psc_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned XW = CW + 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_WAIT,
		S_RD_L,
		S_OP_START,
		S_OP_WAIT,
		S_FINISH
	} state_t;

	state_t              state_q;
	mode_t               mode_q;
	logic [DATA_W-1:0]   value_q;
	logic [7:0]          index_q;
	logic [CW-1:0]       count_q;
	logic [DATA_W-1:0]   right_q;
	logic [DATA_W-1:0]   res_q;
	status_t             stat_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_res_q;
	status_t             out_stat_q;
	logic [8:0]          out_depth_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic [DATA_W-1:0]   alu_y;

	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_m2;
	logic [XW-1:0]       cnt_x;
	logic [XW-1:0]       idx_x;
	logic [XW-1:0]       top_pos;
	logic [CW+8:0]       cnt_depth;
	logic                is_full;
	logic                is_empty;
	logic                is_few;
	logic                idx_bad;
	logic                div_zero;
	logic                out_free;

	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign cnt_x     = {8'd0, count_q};
	assign idx_x     = {{CW{1'b0}}, index_q};
	assign top_pos   = cnt_x - XW'(1) - idx_x;
	assign cnt_depth = {9'd0, count_q};
	assign is_full   = count_q >= CW'(STACK_DEPTH);
	assign is_empty  = count_q == '0;
	assign is_few    = count_q < CW'(2);
	assign idx_bad   = idx_x >= cnt_x;
	assign div_zero  = (mode_q == MODE_DIV) && (right_q == '0);
	assign out_free  = !out_valid_q || !out_stall;

	// memory and ALU control follow the sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = value_q;
		ram_re    = 1'b0;
		ram_raddr = cnt_m1[AW-1:0];
		alu_req   = '{start: 1'b0, op: ALU_ADD};
		unique case (state_q)
			S_DECODE: begin
				case (mode_q) inside
					MODE_PUSH: ram_we = !is_full;
					MODE_POP:  ram_re = !is_empty;
					MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: ram_re = !is_few;
					MODE_PEEK_TOP: begin
						ram_re    = !idx_bad;
						ram_raddr = top_pos[AW-1:0];
					end
					default: begin
						ram_re    = !idx_bad;
						ram_raddr = idx_x[AW-1:0];
					end
				endcase
			end
			S_RD_L: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_m2[AW-1:0];
			end
			S_OP_START: begin
				alu_req.start = !div_zero;
				case (mode_q)
					MODE_ADD: alu_req.op = ALU_ADD;
					MODE_SUB: alu_req.op = ALU_SUB;
					MODE_MUL: alu_req.op = ALU_MUL;
					default:  alu_req.op = ALU_DIV;
				endcase
			end
			S_OP_WAIT: begin
				ram_we    = alu_rsp.done;
				ram_waddr = cnt_m2[AW-1:0];
				ram_wdata = alu_y;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken beat unless a new one loads in this cycle
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode_t'(mode);
						value_q <= value;
						index_q <= index;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (mode_q) inside
						MODE_PUSH: begin
							state_q <= S_FINISH;
							if (is_full) begin
								res_q  <= '0;
								stat_q <= ST_FULL;
							end else begin
								res_q   <= value_q;
								stat_q  <= ST_OK;
								count_q <= count_q + CW'(1);
							end
						end
						MODE_POP: begin
							res_q <= '0;
							if (is_empty) begin
								stat_q  <= ST_EMPTY;
								state_q <= S_FINISH;
							end else begin
								stat_q  <= ST_OK;
								count_q <= cnt_m1;
								state_q <= S_RD_WAIT;
							end
						end
						MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
							res_q <= '0;
							if (is_few) begin
								stat_q  <= ST_FEW;
								state_q <= S_FINISH;
							end else begin
								stat_q  <= ST_OK;
								state_q <= S_RD_L;
							end
						end
						default: begin
							res_q <= '0;
							if (idx_bad) begin
								stat_q  <= ST_BADIDX;
								state_q <= S_FINISH;
							end else begin
								stat_q  <= ST_OK;
								state_q <= S_RD_WAIT;
							end
						end
					endcase
				end
				S_RD_WAIT: begin
					res_q   <= ram_rdata;
					state_q <= S_FINISH;
				end
				S_RD_L: begin
					right_q <= ram_rdata;
					state_q <= S_OP_START;
				end
				S_OP_START: begin
					// divide by zero still consumes both operands
					if (div_zero) begin
						stat_q  <= ST_DIVZERO;
						count_q <= cnt_m2;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_OP_WAIT;
					end
				end
				S_OP_WAIT: begin
					if (alu_rsp.done) begin
						res_q   <= alu_y;
						count_q <= cnt_m1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res_q;
						out_stat_q  <= stat_q;
						out_depth_q <= cnt_depth[8:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	psc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	psc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (ram_rdata),
		.b      (right_q),
		.rsp    (alu_rsp),
		.y      (alu_y)
	);

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign result    = out_res_q;
	assign status    = out_stat_q;
	assign depth     = out_depth_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> result == '0)
		else $error("nonzero result on error status");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_OP_WAIT)
		else $error("ALU done outside operation wait");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("stack read and write in one cycle");

endmodule

### dv/psc_checker.sv
`timescale 1ns / 1ps
// Checker for postfix_stack_calculator_unit: keeps its own copy of the stack, predicts one
// result beat per accepted operation and compares output beats against them in order.
// Depends on psc_pkg.
module psc_checker
	import psc_pkg::*;
#(
	parameter int unsigned DEPTH = STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	input  logic [7:0]         index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] result,
	input  logic [2:0]         status,
	input  logic [8:0]         depth,
	output int unsigned        fail_count,
	output int unsigned        owed_count,
	output int unsigned        checked_count,
	output logic [8:0]         model_depth,
	output logic [8:0]         peak_depth,
	output logic [5:0]         status_seen
);

	typedef struct packed {
		logic [31:0] result;
		status_t     status;
		logic [8:0]  depth;
	} calc_beat_t;

	logic [31:0] stack_mem [DEPTH];
	int unsigned stack_count = 0;
	calc_beat_t  owed_results [$];

	int unsigned fails = 0;
	int unsigned checked = 0;
	int unsigned peak = 0;
	logic [5:0]  status_mask = '0;

	assign fail_count    = fails;
	assign owed_count    = owed_results.size();
	assign checked_count = checked;
	assign model_depth   = stack_count[8:0];
	assign peak_depth    = peak[8:0];
	assign status_seen   = status_mask;

	// Quotient rounded toward minus infinity; -2^31 / -1 wraps back to -2^31.
	function automatic logic [31:0] floor_quotient(logic signed [31:0] lhs,
			logic signed [31:0] rhs);
		longint num;
		longint den;
		longint quo;
		num = lhs;
		den = rhs;
		quo = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			quo = quo - 1;
		return quo[31:0];
	endfunction

	function automatic calc_beat_t apply_stack_op(mode_t op, logic [31:0] operand,
			logic [7:0] pos);
		calc_beat_t beat;
		logic [31:0] lhs;
		logic [31:0] rhs;
		beat.result = '0;
		beat.status = ST_OK;
		case (op)
		MODE_PUSH: begin
			if (stack_count >= DEPTH) begin
				beat.status = ST_FULL;
			end else begin
				stack_mem[stack_count] = operand;
				stack_count++;
				beat.result = operand;
			end
		end
		MODE_POP: begin
			if (stack_count == 0) begin
				beat.status = ST_EMPTY;
			end else begin
				stack_count--;
				beat.result = stack_mem[stack_count];
			end
		end
		MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
			if (stack_count < 2) begin
				beat.status = ST_FEW;
			end else begin
				rhs = stack_mem[stack_count - 1];
				lhs = stack_mem[stack_count - 2];
				stack_count = stack_count - 2;
				case (op)
				MODE_ADD: beat.result = lhs + rhs;
				MODE_SUB: beat.result = lhs - rhs;
				MODE_MUL: beat.result = lhs * rhs;
				default: begin
					if (rhs == '0)
						beat.status = ST_DIVZERO;
					else
						beat.result = floor_quotient(lhs, rhs);
				end
				endcase
				// divide by zero consumes both operands and pushes nothing
				if (beat.status == ST_OK) begin
					stack_mem[stack_count] = beat.result;
					stack_count++;
				end
			end
		end
		default: begin
			if (pos >= stack_count)
				beat.status = ST_BADIDX;
			else if (op == MODE_PEEK_TOP)
				beat.result = stack_mem[stack_count - 1 - pos];
			else
				beat.result = stack_mem[pos];
		end
		endcase
		beat.depth = stack_count[8:0];
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		calc_beat_t want;
		if (!arst_n) begin
			stack_count = 0;
			owed_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (owed_results.size() == 0) begin
					fails++;
					$display("%0t: unexpected result beat, expected none, got result %0d",
						$time, result, " status %0d depth %0d", status, depth);
				end else begin
					want = owed_results.pop_front();
					if (result !== want.result) begin
						fails++;
						$display("%0t: result mismatch, expected %0d, got %0d",
							$time, $signed(want.result), result);
					end
					if (status !== want.status) begin
						fails++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, status);
					end
					if (depth !== want.depth) begin
						fails++;
						$display("%0t: depth mismatch, expected %0d, got %0d",
							$time, want.depth, depth);
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_stack_op(mode_t'(mode), value, index);
				owed_results.push_back(want);
				status_mask[want.status] = 1'b1;
				if (stack_count > peak)
					peak = stack_count;
			end
		end
	end

endmodule

### dv/tb_postfix_stack_calculator_unit.sv
`timescale 1ns / 1ps
// Testbench top for postfix_stack_calculator_unit: drives operation beats with random
// idling and back-pressure, and gives the verdict from the checker's counts.
// Depends on psc_pkg, psc_checker and the block's RTL.
module tb_postfix_stack_calculator_unit;
	import psc_pkg::*;

	localparam int IDLE_LIMIT    = 3000;
	localparam int PRESSURE_HOLD = 300;
	localparam int DRAIN_CYCLES  = 80;
	localparam int PHASE_BLOCKS  = 4;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         mode = MODE_PUSH;
	logic signed [31:0] value = '0;
	logic [7:0]         index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result;
	logic [2:0]         status;
	logic [8:0]         depth;

	int unsigned fail_count;
	int unsigned owed_count;
	int unsigned checked_count;
	logic [8:0]  model_depth;
	logic [8:0]  peak_depth;
	logic [5:0]  status_seen;

	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          hold_requests = 0;
	int unsigned sent_ops = 0;

	mode_t all_modes [8] = '{MODE_PUSH, MODE_POP, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
		MODE_PEEK_TOP, MODE_PEEK_BOT};

	always #4 clk = ~clk;

	postfix_stack_calculator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.status    (status),
		.depth     (depth)
	);

	psc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.value         (value),
		.index         (index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result),
		.status        (status),
		.depth         (depth),
		.fail_count    (fail_count),
		.owed_count    (owed_count),
		.checked_count (checked_count),
		.model_depth   (model_depth),
		.peak_depth    (peak_depth),
		.status_seen   (status_seen)
	);

	// Small values make zero divisors and inexact quotients common.
	function automatic logic [31:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $urandom_range(0, 18) - 9;
		if (r < 50) begin
			case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			default: return 32'h8000_0001;
			endcase
		end
		return $urandom();
	endfunction

	task automatic send_op(input mode_t op, input logic [31:0] operand, input logic [7:0] pos);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= operand;
		index    <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_ops++;
		@(negedge clk);
	endtask

	task automatic random_op(input int push_pct);
		mode_t      op;
		int         r;
		int         live;
		logic [7:0] pos;
		live = int'(model_depth);
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			op = MODE_PUSH;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 12)
				op = MODE_POP;
			else if (r < 62)
				op = all_modes[$urandom_range(2, 5)];
			else if (r < 92)
				op = all_modes[$urandom_range(6, 7)];
			else
				op = all_modes[$urandom_range(0, 7)];
		end
		// aim most peeks inside the live stack
		if (live > 0 && $urandom_range(0, 9) < 8)
			pos = 8'($urandom_range(0, live - 1));
		else
			pos = 8'($urandom_range(0, 255));
		send_op(op, pick_operand(), pos);
	endtask

	task automatic random_run(input int blocks);
		repeat (blocks) begin
			repeat (20) random_op(50);
			repeat (20) random_op(25);
		end
	endtask

	initial begin : sink
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = PRESSURE_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("FAIL postfix_stack_calculator_unit");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct  = 21;
		sink_idle_pct = 78;

		// error paths on an empty or nearly empty stack
		send_op(MODE_POP, $urandom(), 8'd0);
		send_op(MODE_ADD, $urandom(), 8'd0);
		send_op(MODE_PEEK_TOP, $urandom(), 8'd0);
		send_op(MODE_PUSH, 32'h8000_0000, 8'd0);
		send_op(MODE_DIV, $urandom(), 8'd0);
		// -2^31 / -1 wraps
		send_op(MODE_PUSH, 32'hffff_ffff, 8'd255);
		send_op(MODE_DIV, $urandom(), 8'd0);
		// inexact and exact negative quotients
		send_op(MODE_PUSH, 7, 8'd0);
		send_op(MODE_PUSH, -2, 8'd0);
		send_op(MODE_DIV, $urandom(), 8'd0);
		send_op(MODE_PUSH, -6, 8'd0);
		send_op(MODE_PUSH, 3, 8'd0);
		send_op(MODE_DIV, $urandom(), 8'd0);
		// divide by zero drops both operands
		send_op(MODE_PUSH, 0, 8'd0);
		send_op(MODE_DIV, $urandom(), 8'd0);
		send_op(MODE_PUSH, 32'h7fff_ffff, 8'd0);
		send_op(MODE_ADD, $urandom(), 8'd0);
		send_op(MODE_PUSH, 32'h7fff_ffff, 8'd0);
		send_op(MODE_MUL, $urandom(), 8'd0);
		send_op(MODE_PUSH, 5, 8'd0);
		send_op(MODE_SUB, $urandom(), 8'd0);
		send_op(MODE_PEEK_TOP, $urandom(), 8'd0);
		send_op(MODE_PEEK_BOT, $urandom(), 8'd0);
		send_op(MODE_PEEK_TOP, $urandom(), 8'd1);
		send_op(MODE_PEEK_BOT, $urandom(), 8'd255);
		repeat (3) send_op(MODE_POP, $urandom(), 8'd0);

		random_run(PHASE_BLOCKS);

		src_idle_pct  = 78;
		sink_idle_pct = 21;
		random_run(PHASE_BLOCKS);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		// hold the output off while beats keep coming, so the input stalls
		hold_requests++;
		random_run(PHASE_BLOCKS);

		// fill to the top, push into a full stack, peek the far ends, then drain
		while (model_depth < STACK_DEPTH_DEF)
			send_op(MODE_PUSH, pick_operand(), 8'($urandom_range(0, 255)));
		repeat (3) send_op(MODE_PUSH, pick_operand(), 8'($urandom_range(0, 255)));
		send_op(MODE_PEEK_TOP, $urandom(), 8'd255);
		send_op(MODE_PEEK_BOT, $urandom(), 8'd255);
		repeat (10) random_op(50);
		while (model_depth > 8)
			send_op(all_modes[$urandom_range(1, 5)], $urandom(), 8'($urandom_range(0, 255)));

		in_valid <= 1'b0;
		while (owed_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (owed_count != 0)
			$display("%0t: %0d expected results never arrived", $time, owed_count);
		$display("Sent %0d operations and checked %0d results; stack depth reached %0d.",
			sent_ops, checked_count, peak_depth);
		$display("Status codes seen (bit per code, ok at bit 0): %b", status_seen);
		if (fail_count == 0 && owed_count == 0)
			$display("PASS postfix_stack_calculator_unit");
		else
			$display("FAIL postfix_stack_calculator_unit");
		$finish;
	end

endmodule

### filelist.f
design/psc_pkg.sv
design/psc_ram.sv
design/psc_alu.sv
design/postfix_stack_calculator_unit.sv
dv/psc_checker.sv
dv/tb_postfix_stack_calculator_unit.sv
